>>> rtl/core/nmea_sentence_checksum_checker_macros.svh
// Assertion macros shared by the NMEA sentence checksum checker RTL.
`ifndef NMEA_SENTENCE_CHECKSUM_CHECKER_MACROS_SVH
`define NMEA_SENTENCE_CHECKSUM_CHECKER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define NSC_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define NSC_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/nsc_pkg.sv
// Package with types, character codes and helpers for the NMEA checksum checker.
`timescale 1ns / 1ps
`default_nettype none

package nsc_pkg;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_BANG   = 8'h21;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;

   localparam logic [7:0] MAX_BODY_LENGTH_RESET = 8'd80;

   typedef enum logic [1:0] {
      PH_WAIT = 2'd0,
      PH_BODY = 2'd1,
      PH_SUM  = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      EV_IGNORED  = 3'd0,
      EV_ACCEPT   = 3'd1,
      EV_VALID    = 3'd2,
      EV_MISMATCH = 3'd3,
      EV_DROP     = 3'd4
   } event_type;

   typedef struct packed {
      event_type  event_res;
      logic [7:0] received_checksum;
      logic [7:0] computed_checksum;
   } result_type;

   // Returns {is_hex, nibble} for an ASCII hex digit of either case.
   function automatic logic [4:0] hex_decode(input logic [7:0] b);
      logic [7:0] d;
      logic       ok;
      begin
         d  = 8'd0;
         ok = 1'b1;
         if (b inside {[8'h30:8'h39]}) begin
            d = b - 8'h30;
         end else if (b inside {[8'h61:8'h66]}) begin
            d = b - 8'h57;
         end else if (b inside {[8'h41:8'h46]}) begin
            d = b - 8'h37;
         end else begin
            ok = 1'b0;
         end
         hex_decode = {ok, d[3:0]};
      end
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/nmea_sentence_checksum_checker.sv
// Top level of the NMEA 0183 sentence checksum checker.
//
// The req channel takes one received character per beat on req_rx_byte.
// The rsp channel returns exactly one beat per request beat, in order:
// rsp_event_res (0 ignored, 1 sentence byte, 2 valid, 3 mismatch,
// 4 dropped), the echoed byte, and on valid or mismatch the received and
// computed checksums (zero otherwise).
// The csr port writes the maximum body length; write it only while idle.
// A request beat is held in an input register and is parsed on its way to
// the output register, which drives rsp_valid and the result beat. One beat
// is taken every cycle when rsp_ready is high.
// The per-byte state update in the parser is the only logic in that path.
// When the receiver stalls, the output register holds its beat and the
// input register takes one more beat before req_ready goes low.
// Reset is synchronous: both registers empty, the parser waits for a start
// character, and the body length limit returns to 80.
`timescale 1ns / 1ps
`default_nettype none

`include "nmea_sentence_checksum_checker_macros.svh"

module nmea_sentence_checksum_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output wire logic       req_ready,
   input  wire logic [7:0] req_rx_byte,
   output wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   output wire logic [2:0] rsp_event_res,
   output wire logic [7:0] rsp_data_byte,
   output wire logic [7:0] rsp_received_checksum,
   output wire logic [7:0] rsp_computed_checksum,
   input  wire logic       csr_write_enable,
   input  wire logic [7:0] csr_write_data
);

   logic [7:0] max_body_length_ff;
   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       out_valid_ff;
   logic [2:0] out_event_ff;
   logic [7:0] out_byte_ff;
   logic [7:0] out_rx_sum_ff;
   logic [7:0] out_comp_sum_ff;
   logic       advance;
   logic       req_take;
   nsc_pkg::result_type result;

   assign advance  = !out_valid_ff || rsp_ready;
   assign req_take = req_valid && req_ready;

   assign req_ready             = !s1_valid_ff || advance;
   assign rsp_valid             = out_valid_ff;
   assign rsp_event_res         = out_event_ff;
   assign rsp_data_byte         = out_byte_ff;
   assign rsp_received_checksum = out_rx_sum_ff;
   assign rsp_computed_checksum = out_comp_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_body_length_ff <= nsc_pkg::MAX_BODY_LENGTH_RESET;
      end else if (csr_write_enable) begin
         max_body_length_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_rx_byte;
      end
   end

   nsc_parser u_parser (
      .clock           (clock),
      .reset           (reset),
      .step            (s1_valid_ff && advance),
      .rx_byte         (s1_byte_ff),
      .max_body_length (max_body_length_ff),
      .result          (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         out_event_ff    <= result.event_res;
         out_byte_ff     <= s1_byte_ff;
         out_rx_sum_ff   <= result.received_checksum;
         out_comp_sum_ff <= result.computed_checksum;
      end
   end

   `NSC_ASSERT_SAME(a_event_range, clock, reset, out_valid_ff,
      out_event_ff <= nsc_pkg::EV_DROP, "event code out of range")
   `NSC_ASSERT_SAME(a_sums_zero, clock, reset,
      out_valid_ff && (out_event_ff != nsc_pkg::EV_VALID)
         && (out_event_ff != nsc_pkg::EV_MISMATCH),
      (out_rx_sum_ff == 8'd0) && (out_comp_sum_ff == 8'd0),
      "checksums must be zero outside sentence end")
   `NSC_ASSERT_SAME(a_valid_match, clock, reset,
      out_valid_ff && (out_event_ff == nsc_pkg::EV_VALID),
      out_rx_sum_ff == out_comp_sum_ff, "valid sentence with unequal checksums")
   `NSC_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !advance,
      s1_valid_ff && $stable(s1_byte_ff), "input register lost a beat while stalled")
   `NSC_ASSERT_SAME(a_ready_full, clock, reset, !req_ready,
      s1_valid_ff && out_valid_ff, "input blocked with free storage")

endmodule

`default_nettype wire

>>> rtl/core/nsc_parser.sv
// Sentence state and per-byte parse logic of the NMEA checksum checker.
`timescale 1ns / 1ps
`default_nettype none

module nsc_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [7:0]         rx_byte,
   input  wire logic [7:0]         max_body_length,
   output nsc_pkg::result_type     result
);

   nsc_pkg::phase_type phase_ff, phase_in;
   logic [7:0] parity_ff, parity_in;
   logic [7:0] body_count_ff, body_count_in;
   logic [7:0] checksum_ff, checksum_in;
   logic [1:0] digits_ff, digits_in;
   logic       stopped_ff, stopped_in;

   logic       eol;
   logic [4:0] hex;

   assign eol = (rx_byte == nsc_pkg::CHAR_CR) || (rx_byte == nsc_pkg::CHAR_LF);
   assign hex = nsc_pkg::hex_decode(rx_byte);

   always_comb begin
      phase_in      = phase_ff;
      parity_in     = parity_ff;
      body_count_in = body_count_ff;
      checksum_in   = checksum_ff;
      digits_in     = digits_ff;
      stopped_in    = stopped_ff;
      result.event_res         = nsc_pkg::EV_IGNORED;
      result.received_checksum = 8'd0;
      result.computed_checksum = 8'd0;
      case (phase_ff)
         nsc_pkg::PH_BODY: begin
            if (eol) begin
               phase_in         = nsc_pkg::PH_WAIT;
               result.event_res = nsc_pkg::EV_DROP;
            end else if (rx_byte == nsc_pkg::CHAR_STAR) begin
               phase_in         = nsc_pkg::PH_SUM;
               checksum_in      = 8'd0;
               digits_in        = 2'd0;
               stopped_in       = 1'b0;
               result.event_res = nsc_pkg::EV_ACCEPT;
            end else if (body_count_ff >= max_body_length) begin
               phase_in         = nsc_pkg::PH_WAIT;
               result.event_res = nsc_pkg::EV_DROP;
            end else begin
               body_count_in    = body_count_ff + 8'd1;
               parity_in        = parity_ff ^ rx_byte;
               result.event_res = nsc_pkg::EV_ACCEPT;
            end
         end
         nsc_pkg::PH_SUM: begin
            if ((rx_byte == nsc_pkg::CHAR_COMMA) || (rx_byte == nsc_pkg::CHAR_STAR)) begin
               phase_in         = nsc_pkg::PH_WAIT;
               result.event_res = nsc_pkg::EV_DROP;
            end else if (eol) begin
               phase_in                 = nsc_pkg::PH_WAIT;
               result.received_checksum = checksum_ff;
               result.computed_checksum = parity_ff;
               if ((digits_ff != 2'd0) && (checksum_ff == parity_ff)) begin
                  result.event_res = nsc_pkg::EV_VALID;
               end else begin
                  result.event_res = nsc_pkg::EV_MISMATCH;
               end
            end else begin
               if (!stopped_ff && (digits_ff < 2'd2)) begin
                  if (!hex[4]) begin
                     stopped_in = 1'b1;
                  end else begin
                     checksum_in = {checksum_ff[3:0], hex[3:0]};
                     digits_in   = digits_ff + 2'd1;
                  end
               end
               result.event_res = nsc_pkg::EV_ACCEPT;
            end
         end
         default: begin
            phase_in = nsc_pkg::PH_WAIT;
            if ((rx_byte == nsc_pkg::CHAR_DOLLAR) || (rx_byte == nsc_pkg::CHAR_BANG)) begin
               phase_in         = nsc_pkg::PH_BODY;
               parity_in        = 8'd0;
               body_count_in    = 8'd0;
               checksum_in      = 8'd0;
               digits_in        = 2'd0;
               stopped_in       = 1'b0;
               result.event_res = nsc_pkg::EV_ACCEPT;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= nsc_pkg::PH_WAIT;
         parity_ff     <= 8'd0;
         body_count_ff <= 8'd0;
         checksum_ff   <= 8'd0;
         digits_ff     <= 2'd0;
         stopped_ff    <= 1'b0;
      end else if (step) begin
         phase_ff      <= phase_in;
         parity_ff     <= parity_in;
         body_count_ff <= body_count_in;
         checksum_ff   <= checksum_in;
         digits_ff     <= digits_in;
         stopped_ff    <= stopped_in;
      end
   end

endmodule

`default_nettype wire
